FILE: sv/ias_pkg.sv
// ----------------------------------------------------------------------------
// ias_pkg
// Shared types and constants for the interval activity selector: payload
// structs, controller states and the controller/datapath command and status
// groups.
// ----------------------------------------------------------------------------
package ias_pkg;

    localparam int TIME_BITS  = 16;  // width of start/end times
    localparam int INDEX_BITS = 6;   // width of entry_index on the output
    localparam int COUNT_BITS = 7;   // width of chosen_count on the output

    typedef struct packed {
        logic [TIME_BITS-1:0] start_time;
        logic [TIME_BITS-1:0] end_time;
        logic                 is_last;
    } t_in_item;

    typedef struct packed {
        logic [INDEX_BITS-1:0] entry_index;
        logic [TIME_BITS-1:0]  chosen_start;
        logic [TIME_BITS-1:0]  chosen_end;
        logic [COUNT_BITS-1:0] chosen_count;
        logic                  final_choice;
        logic                  overflow_seen;
    } t_out_item;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SORT_CHK,
        S_SORT_LDI,
        S_SORT_RDJ,
        S_SORT_CMP,
        S_SEL_RD,
        S_SEL_CMP,
        S_FLUSH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_en;     // input item accepted
        logic rd_en;       // memory read
        logic rd_at_j;     // read address: 1 = j, 0 = i
        logic wr_cur;      // write held entry back to memory
        logic wr_at_j;     // write address: 1 = j, 0 = i
        logic cur_ld;      // held entry <= read data
        logic j_set;       // j <= i + 1
        logic j_inc;
        logic i_inc;
        logic i_clr;
        logic choose;      // read entry is chosen, goes to hold register
        logic push;        // hold register -> output register
        logic push_final;  // pushed item is the last of the run
        logic run_clr;     // end of run, clear run state
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic i_next_lt_n;  // i + 1 < n
        logic j_lt_n;
        logic i_lt_n;
        logic swap;         // held end > read end
        logic chosen;       // read entry passes greedy test
        logic hold_valid;
        logic out_free;     // output register can take an item this cycle
    } t_status;

endpackage

FILE: sv/ias_ctrl.sv
// ----------------------------------------------------------------------------
// ias_ctrl
// Sequencer for the selector: load, exchange sort over the interval memory,
// greedy selection walk and final flush.
// ----------------------------------------------------------------------------
module ias_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_last,
    output logic            o_in_ready,
    input  ias_pkg::t_status i_status,
    output ias_pkg::t_cmd    o_cmd
);
    import ias_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_en = 1'b1;
                    if (i_in_last) begin
                        n_state = S_SORT_CHK;
                    end
                end
            end
            S_SORT_CHK: begin
                if (i_status.i_next_lt_n) begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.j_set = 1'b1;
                    n_state     = S_SORT_LDI;
                end else begin
                    o_cmd.i_clr = 1'b1;
                    n_state     = S_SEL_RD;
                end
            end
            S_SORT_LDI: begin
                o_cmd.cur_ld = 1'b1;
                n_state      = S_SORT_RDJ;
            end
            S_SORT_RDJ: begin
                if (i_status.j_lt_n) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_at_j = 1'b1;
                    n_state       = S_SORT_CMP;
                end else begin
                    // slot i is settled
                    o_cmd.wr_cur = 1'b1;
                    o_cmd.i_inc  = 1'b1;
                    n_state      = S_SORT_CHK;
                end
            end
            S_SORT_CMP: begin
                if (i_status.swap) begin
                    o_cmd.wr_cur  = 1'b1;
                    o_cmd.wr_at_j = 1'b1;
                    o_cmd.cur_ld  = 1'b1;
                end
                o_cmd.j_inc = 1'b1;
                n_state     = S_SORT_RDJ;
            end
            S_SEL_RD: begin
                if (i_status.i_lt_n) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_SEL_CMP;
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_SEL_CMP: begin
                if (!i_status.chosen) begin
                    o_cmd.i_inc = 1'b1;
                    n_state     = S_SEL_RD;
                end else if (!i_status.hold_valid || i_status.out_free) begin
                    o_cmd.choose = 1'b1;
                    o_cmd.push   = i_status.hold_valid;
                    o_cmd.i_inc  = 1'b1;
                    n_state      = S_SEL_RD;
                end
            end
            S_FLUSH: begin
                if (i_status.out_free) begin
                    o_cmd.push       = 1'b1;
                    o_cmd.push_final = 1'b1;
                    o_cmd.run_clr    = 1'b1;
                    n_state          = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

FILE: sv/ias_datapath.sv
// ----------------------------------------------------------------------------
// ias_datapath
// Interval memory, sort/selection indexes, held entry, greedy state, hold
// register for the pending result and the output register.
// ----------------------------------------------------------------------------
module ias_datapath #(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ias_pkg::t_in_item  i_in_item,
    input  ias_pkg::t_cmd      i_cmd,
    output ias_pkg::t_status   o_status,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output ias_pkg::t_out_item o_out_item
);
    import ias_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_W = CW'(1);

    typedef struct packed {
        logic [IW-1:0]        idx;
        logic [TIME_BITS-1:0] s;
        logic [TIME_BITS-1:0] e;
    } t_entry;

    t_entry mem [CAPACITY];

    logic [CW-1:0]        r_count;
    logic                 r_dropped;
    logic [CW-1:0]        r_i;
    logic [CW-1:0]        r_j;
    t_entry               r_cur;
    t_entry               r_rd;
    logic [TIME_BITS-1:0] r_last_end;
    logic                 r_any;
    logic [CW-1:0]        r_picked;
    t_out_item            r_hold;
    logic                 r_hold_valid;
    t_out_item            r_out;
    logic                 r_out_valid;

    logic                 has_room;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    t_entry               wr_data;
    logic [IW-1:0]        rd_addr;
    logic [CW-1:0]        i_next;
    logic [CW-1:0]        picked_next;
    logic [IW+INDEX_BITS-1:0] idx_ext;
    logic [CW+COUNT_BITS-1:0] cnt_ext;
    logic                 out_free;
    t_out_item            push_item;

    assign has_room    = (r_count < CAP_W);
    assign i_next      = r_i + ONE_W;
    assign picked_next = r_picked + ONE_W;
    assign out_free    = !r_out_valid || i_out_ready;
    assign idx_ext     = {{INDEX_BITS{1'b0}}, r_rd.idx};
    assign cnt_ext     = {{COUNT_BITS{1'b0}}, picked_next};

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_i[IW-1:0];
        wr_data = r_cur;
        if (i_cmd.load_en) begin
            wr_en           = has_room;
            wr_addr         = r_count[IW-1:0];
            wr_data.idx     = r_count[IW-1:0];
            wr_data.s       = i_in_item.start_time;
            wr_data.e       = i_in_item.end_time;
        end else if (i_cmd.wr_cur) begin
            wr_en   = 1'b1;
            wr_addr = i_cmd.wr_at_j ? r_j[IW-1:0] : r_i[IW-1:0];
        end
    end

    assign rd_addr = i_cmd.rd_at_j ? r_j[IW-1:0] : r_i[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    // held entry (slot i during the inner sort pass)
    always_ff @(posedge i_clk) begin
        if (i_cmd.cur_ld) begin
            r_cur <= r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_dropped    <= 1'b0;
            r_i          <= '0;
            r_j          <= '0;
            r_last_end   <= '0;
            r_any        <= 1'b0;
            r_picked     <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load_en) begin
                if (has_room) begin
                    r_count <= r_count + ONE_W;
                end else begin
                    r_dropped <= 1'b1;
                end
            end
            if (i_cmd.i_clr) begin
                r_i <= '0;
            end else if (i_cmd.i_inc) begin
                r_i <= i_next;
            end
            if (i_cmd.j_set) begin
                r_j <= i_next;
            end else if (i_cmd.j_inc) begin
                r_j <= r_j + ONE_W;
            end
            if (i_cmd.choose) begin
                r_any        <= 1'b1;
                r_last_end   <= r_rd.e;
                r_picked     <= picked_next;
                r_hold_valid <= 1'b1;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.run_clr) begin
                r_count      <= '0;
                r_dropped    <= 1'b0;
                r_i          <= '0;
                r_last_end   <= '0;
                r_any        <= 1'b0;
                r_picked     <= '0;
                r_hold_valid <= 1'b0;
            end
        end
    end

    // held result with its run flags filled in on the way out
    always_comb begin
        push_item               = r_hold;
        push_item.final_choice  = i_cmd.push_final;
        push_item.overflow_seen = r_dropped;
    end

    // pending result and output register payloads
    always_ff @(posedge i_clk) begin
        if (i_cmd.choose) begin
            r_hold.entry_index   <= idx_ext[INDEX_BITS-1:0];
            r_hold.chosen_start  <= r_rd.s;
            r_hold.chosen_end    <= r_rd.e;
            r_hold.chosen_count  <= cnt_ext[COUNT_BITS-1:0];
            r_hold.final_choice  <= 1'b0;
            r_hold.overflow_seen <= 1'b0;
        end
        if (i_cmd.push) begin
            r_out <= push_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign o_status.i_next_lt_n = (i_next < r_count);
    assign o_status.j_lt_n      = (r_j < r_count);
    assign o_status.i_lt_n      = (r_i < r_count);
    assign o_status.swap        = (r_cur.e > r_rd.e);
    assign o_status.chosen      = !r_any || (r_rd.s >= r_last_end);
    assign o_status.hold_valid  = r_hold_valid;
    assign o_status.out_free    = out_free;

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> out_free)
        else $error("push into a full output register");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_W)
        else $error("load count above capacity");

    a_i_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_i <= r_count)
        else $error("walk index past loaded count");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push && i_cmd.push_final) |=> (!r_hold_valid && r_count == '0))
        else $error("run state not cleared after final item");

endmodule

FILE: sv/interval_activity_selector.sv
// ----------------------------------------------------------------------------
// interval_activity_selector
// Greedy activity selection: loads intervals, orders them by end time with
// an exchange sort, then emits every interval that can be chosen greedily.
// ----------------------------------------------------------------------------
// Intervals are taken one item per cycle while loading; the item with
// is_last set closes the set. Up to CAPACITY intervals are stored in one
// memory; items beyond that are accepted, dropped and reported through
// overflow_seen on every result of the run. After the last item the input
// channel stays closed until the last result of the run has moved into the
// output register. The sort is an exchange sort over the interval memory
// (one read and one write a cycle). The selection walk then reads each
// stored interval in turn and tests it against the end of the last chosen
// one, then does an end-of-list check and flushes the held result, waiting
// whenever the output side stalls.
// Results come in end-time order with the original load position, a running
// count from 1, and final_choice set on the last one.
// Each chosen interval is held back one step so that the last result can be
// flagged; the output is a register, so the sink may stall at any time.
// ----------------------------------------------------------------------------
module interval_activity_selector #(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ias_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ias_pkg::t_out_item o_out_item
);
    import ias_pkg::*;

    t_cmd    cmd;     // controller commands
    t_status status;  // datapath flags back to the controller

    // Controller: load / sort / select / flush sequencing.
    ias_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_item.is_last),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath: interval memory, indexes, greedy state, output register.
    ias_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives interval sets into interval_activity_selector and checks every
// chosen interval against a local model of the exchange sort and greedy walk.
// A short table of hand-picked sets runs first, then full, overflowing and
// random sets, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import ias_pkg::*;

    localparam int SET_CAPACITY = 64;
    localparam int ITEM_BUDGET  = 460;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 50;

    // One row of the directed table; answer is only used when known is set
    typedef struct packed {
        t_in_item  item;
        logic      known;
        t_out_item answer;
    } t_dir_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    interval_activity_selector #(
        .CAPACITY(SET_CAPACITY)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    // Local copy of the interval store for the set being loaded
    logic [TIME_BITS-1:0]  set_start [SET_CAPACITY];
    logic [TIME_BITS-1:0]  set_end   [SET_CAPACITY];
    logic [INDEX_BITS-1:0] set_pos   [SET_CAPACITY];
    int                    set_fill    = 0;
    bit                    set_dropped = 1'b0;

    t_out_item fresh_choices[$];    // choices produced by the item just taken
    t_out_item awaited_choices[$];  // choices still owed by the block

    int items_sent      = 0;
    int sets_sent       = 0;
    int overflow_sets   = 0;
    int choices_checked = 0;
    int mismatch_count  = 0;
    int stray_count     = 0;
    int report_count    = 0;
    bit calm            = 1'b0;     // no idling on either side while set

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #10_000_000;
        $display("[interval_activity_selector] ERROR");
        $finish;
    end

    // Store one interval; on the last one of a set, sort by end time with the
    // exchange rule (equal ends may be reordered), then walk greedily.
    function automatic void absorb_interval(input t_in_item it);
        logic [TIME_BITS-1:0]  tmp_time;
        logic [INDEX_BITS-1:0] tmp_pos;
        logic [TIME_BITS-1:0]  reach;
        logic [COUNT_BITS-1:0] picked;
        bit                    any;
        t_out_item             r;
        int                    i;
        int                    j;
        fresh_choices.delete();
        if (set_fill < SET_CAPACITY) begin
            set_start[set_fill] = it.start_time;
            set_end[set_fill]   = it.end_time;
            set_pos[set_fill]   = INDEX_BITS'(set_fill);
            set_fill++;
        end else begin
            set_dropped = 1'b1;
        end
        if (!it.is_last) return;

        for (i = 0; i + 1 < set_fill; i++) begin
            for (j = i + 1; j < set_fill; j++) begin
                if (set_end[i] > set_end[j]) begin
                    tmp_time = set_start[i]; set_start[i] = set_start[j]; set_start[j] = tmp_time;
                    tmp_time = set_end[i];   set_end[i]   = set_end[j];   set_end[j]   = tmp_time;
                    tmp_pos  = set_pos[i];   set_pos[i]   = set_pos[j];   set_pos[j]   = tmp_pos;
                end
            end
        end

        reach  = '0;
        picked = '0;
        any    = 1'b0;
        for (i = 0; i < set_fill; i++) begin
            if (!any || set_start[i] >= reach) begin
                any    = 1'b1;
                reach  = set_end[i];
                picked = picked + 1'b1;
                r.entry_index   = set_pos[i];
                r.chosen_start  = set_start[i];
                r.chosen_end    = set_end[i];
                r.chosen_count  = picked;
                r.final_choice  = 1'b0;
                r.overflow_seen = set_dropped;
                fresh_choices.push_back(r);
            end
        end
        r = fresh_choices.pop_back();
        r.final_choice = 1'b1;
        fresh_choices.push_back(r);

        sets_sent++;
        if (set_dropped) overflow_sets++;
        set_fill    = 0;
        set_dropped = 1'b0;
    endfunction

    function automatic t_dir_row dir_row(input logic [TIME_BITS-1:0] s,
                                         input logic [TIME_BITS-1:0] e,
                                         input logic last,
                                         input logic known,
                                         input t_out_item answer);
        t_dir_row row;
        row.item.start_time = s;
        row.item.end_time   = e;
        row.item.is_last    = last;
        row.known           = known;
        row.answer          = answer;
        return row;
    endfunction

    // Offer one interval, holding valid and payload until it is taken.
    // Called at the edge where the previous item was taken, so valid gets
    // only one update per edge.
    task automatic send_interval(input t_in_item it, input bit known,
                                 input t_out_item answer);
        int gap;
        gap = (!calm && $urandom_range(0, 99) < 16) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        absorb_interval(it);
        if (known) begin
            fresh_choices.delete();
            fresh_choices.push_back(answer);
        end
        foreach (fresh_choices[k]) awaited_choices.push_back(fresh_choices[k]);
    endtask

    // Hold off the sender until everything owed has come out
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_choices.size() != 0);
    endtask

    // One set of random intervals. Mostly well-formed intervals, either
    // clustered near zero (many ties and touching ends) or spread over the
    // full range; about one in ten is arbitrary noise.
    task automatic send_random_set(input int size);
        t_in_item           it;
        bit                 wide;
        logic [TIME_BITS:0] stretch;
        int                 k;
        wide = 1'($urandom_range(0, 1));
        for (k = 0; k < size; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                it.start_time = TIME_BITS'($urandom);
                it.end_time   = TIME_BITS'($urandom);
            end else if (wide) begin
                it.start_time = TIME_BITS'($urandom);
                stretch = {1'b0, it.start_time} + (TIME_BITS+1)'($urandom_range(0, 16383));
                it.end_time = stretch[TIME_BITS] ? '1 : stretch[TIME_BITS-1:0];
            end else begin
                it.start_time = TIME_BITS'($urandom_range(0, 48));
                it.end_time   = it.start_time + TIME_BITS'($urandom_range(0, 10));
            end
            it.is_last = (k == size - 1);
            send_interval(it, 1'b0, '0);
        end
    endtask

    task automatic check_choice(input t_out_item got);
        t_out_item want;
        bit        bad;
        if (awaited_choices.size() == 0) begin
            stray_count++;
            if (report_count < MAX_REPORTS) begin
                report_count++;
                $display("result with nothing pending: idx %0d start %h end %h count %0d",
                         got.entry_index, got.chosen_start, got.chosen_end,
                         got.chosen_count);
            end
        end else begin
            want = awaited_choices.pop_front();
            choices_checked++;
            bad = (got.entry_index   !== want.entry_index)  ||
                  (got.chosen_start  !== want.chosen_start) ||
                  (got.chosen_end    !== want.chosen_end)   ||
                  (got.chosen_count  !== want.chosen_count) ||
                  (got.final_choice  !== want.final_choice) ||
                  (got.overflow_seen !== want.overflow_seen);
            if (bad) begin
                mismatch_count++;
                if (report_count < MAX_REPORTS) begin
                    report_count++;
                    $display("mismatch: exp idx %0d start %h end %h count %0d fin %b ovf %b",
                             want.entry_index, want.chosen_start, want.chosen_end,
                             want.chosen_count, want.final_choice, want.overflow_seen);
                    $display("          got idx %0d start %h end %h count %0d fin %b ovf %b",
                             got.entry_index, got.chosen_start, got.chosen_end,
                             got.chosen_count, got.final_choice, got.overflow_seen);
                end
            end
        end
    endtask

    // Result side: check on every taken item, then pick next cycle's ready.
    // Values are read as they stood before the edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) check_choice(o_out_item);
            i_out_ready <= calm || ($urandom_range(0, 99) >= 16);
        end
    end

    initial begin
        t_dir_row dir_rows[$];
        int       pick;
        int       size;
        bit       paused_mid;
        paused_mid = 1'b0;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_out_ready <= 1'b0;

        // Single-interval sets at the extremes: the only interval is always
        // chosen, even when its start lies past its end.
        dir_rows.push_back(dir_row(16'h0000, 16'h0000, 1'b1, 1'b1,
                                   {6'd0, 16'h0000, 16'h0000, 7'd1, 1'b1, 1'b0}));
        dir_rows.push_back(dir_row(16'hFFFF, 16'hFFFF, 1'b1, 1'b1,
                                   {6'd0, 16'hFFFF, 16'hFFFF, 7'd1, 1'b1, 1'b0}));
        dir_rows.push_back(dir_row(16'hFFFF, 16'h0000, 1'b1, 1'b1,
                                   {6'd0, 16'hFFFF, 16'h0000, 7'd1, 1'b1, 1'b0}));
        // Equal end times: load order decides; a start equal to the last end
        // is accepted.
        dir_rows.push_back(dir_row(16'h0005, 16'h000A, 1'b0, 1'b0, '0));
        dir_rows.push_back(dir_row(16'h0003, 16'h000A, 1'b0, 1'b0, '0));
        dir_rows.push_back(dir_row(16'h000A, 16'h000A, 1'b1, 1'b0, '0));
        // A long interval loaded first ends up last after sorting
        dir_rows.push_back(dir_row(16'h0000, 16'hFFFF, 1'b0, 1'b0, '0));
        dir_rows.push_back(dir_row(16'h0001, 16'h0002, 1'b0, 1'b0, '0));
        dir_rows.push_back(dir_row(16'h0002, 16'h0003, 1'b0, 1'b0, '0));
        dir_rows.push_back(dir_row(16'h0003, 16'h0004, 1'b1, 1'b0, '0));
        // Alternating bit patterns, duplicate intervals
        dir_rows.push_back(dir_row(16'hAAAA, 16'h5555, 1'b0, 1'b0, '0));
        dir_rows.push_back(dir_row(16'h5555, 16'hAAAA, 1'b0, 1'b0, '0));
        dir_rows.push_back(dir_row(16'h5555, 16'hAAAA, 1'b1, 1'b0, '0));
        // Reversed load order: every pair gets exchanged
        dir_rows.push_back(dir_row(16'h0030, 16'h0040, 1'b0, 1'b0, '0));
        dir_rows.push_back(dir_row(16'h0020, 16'h0030, 1'b0, 1'b0, '0));
        dir_rows.push_back(dir_row(16'h0010, 16'h0020, 1'b0, 1'b0, '0));
        dir_rows.push_back(dir_row(16'h0000, 16'h0010, 1'b1, 1'b0, '0));
        // Start past end inside a larger set
        dir_rows.push_back(dir_row(16'h0010, 16'h0008, 1'b0, 1'b0, '0));
        dir_rows.push_back(dir_row(16'h0000, 16'h0004, 1'b0, 1'b0, '0));
        dir_rows.push_back(dir_row(16'h0004, 16'h0008, 1'b1, 1'b0, '0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) send_interval(dir_rows[r].item, dir_rows[r].known,
                                            dir_rows[r].answer);
        drain_results();

        // Store exactly full, one over (the last item itself is dropped),
        // and well past capacity
        send_random_set(SET_CAPACITY);
        send_random_set(SET_CAPACITY + 1);
        send_random_set(SET_CAPACITY + 6);

        // Random sets, mostly small; the sort time grows with the square
        // of the set size
        while (items_sent < ITEM_BUDGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                size = $urandom_range(1, 8);
            end else if (pick < 92) begin
                size = $urandom_range(9, 24);
            end else begin
                size = $urandom_range(25, SET_CAPACITY);
            end
            calm = (items_sent >= 300 && items_sent < 390);
            send_random_set(size);
            if (!paused_mid && items_sent >= 230) begin
                drain_results();
                paused_mid = 1'b1;
            end
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        while (awaited_choices.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d intervals in %0d sets, %0d sets over capacity",
                 items_sent, sets_sent, overflow_sets);
        $display("checked %0d chosen intervals, %0d mismatches, %0d unexpected",
                 choices_checked, mismatch_count, stray_count);
        if (mismatch_count == 0 && stray_count == 0 && awaited_choices.size() == 0) begin
            $display("[interval_activity_selector] OK");
        end else begin
            $display("[interval_activity_selector] ERROR");
        end
        $finish;
    end

endmodule
